[rtl/core/prrd_pkg.sv]
// ----------------------------------------------------------------------------
// prrd_pkg
// Shared constants, register codes, cell word types and the arctangent table
// for the point to rotated rectangle distance pipeline.
// ----------------------------------------------------------------------------
package prrd_pkg;

	// rotation steps, limited to the table length
	localparam int TRIG_ITERATIONS = 16;
	localparam int CORDIC_MAX      = 24;
	localparam int CORDIC_N        = (TRIG_ITERATIONS < CORDIC_MAX) ?
		TRIG_ITERATIONS : CORDIC_MAX;
	localparam int IDX_W           = 5;

	// square root: one result bit per cell
	localparam int RAD_W  = 54;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	localparam logic signed [33:0] CORDIC_K      = 34'sd652032874;
	localparam logic [29:0]        QUARTER_PI    = 30'd843314857;
	localparam logic [19:0]        DIST_MAX      = 20'hFFFFF;

	// register indexes
	localparam logic [2:0] REG_LEFT   = 3'd0;
	localparam logic [2:0] REG_RIGHT  = 3'd1;
	localparam logic [2:0] REG_TOP    = 3'd2;
	localparam logic [2:0] REG_BOTTOM = 3'd3;
	localparam logic [2:0] REG_XSCALE = 3'd4;
	localparam logic [2:0] REG_YSCALE = 3'd5;
	localparam logic [2:0] REG_ANGLE  = 3'd6;

	// word handed between rotation cells
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] z;
		logic [1:0]         quad;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic [32:0]        hx;
		logic [32:0]        hy;
	} cordic_t;

	// word handed between root cells
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
	} sqrt_t;

	// arctangent of 2^-i in Q2.30
	function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] i);
		logic [29:0] a;
		case (i)
			5'd0:  a = 30'd843314856;
			5'd1:  a = 30'd497837829;
			5'd2:  a = 30'd263043836;
			5'd3:  a = 30'd133525158;
			5'd4:  a = 30'd67021686;
			5'd5:  a = 30'd33543515;
			5'd6:  a = 30'd16775850;
			5'd7:  a = 30'd8388437;
			5'd8:  a = 30'd4194282;
			5'd9:  a = 30'd2097149;
			5'd10: a = 30'd1048575;
			5'd11: a = 30'd524287;
			5'd12: a = 30'd262143;
			5'd13: a = 30'd131071;
			5'd14: a = 30'd65535;
			5'd15: a = 30'd32767;
			5'd16: a = 30'd16383;
			5'd17: a = 30'd8191;
			5'd18: a = 30'd4095;
			5'd19: a = 30'd2047;
			5'd20: a = 30'd1023;
			5'd21: a = 30'd511;
			5'd22: a = 30'd255;
			5'd23: a = 30'd127;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

endpackage

[rtl/core/prrd_cordic_cell.sv]
// ----------------------------------------------------------------------------
// prrd_cordic_cell
// One rotation-mode step: shift-add of x and y, angle update, registered.
// ----------------------------------------------------------------------------
module prrd_cordic_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [prrd_pkg::IDX_W-1:0] idx,
	input  logic                     in_v,
	input  prrd_pkg::cordic_t        in_w,
	output logic                     out_v,
	output prrd_pkg::cordic_t        out_w
);
	import prrd_pkg::*;

	cordic_t nxt;
	logic signed [33:0] xs, ys;
	logic signed [31:0] at;

	// shift-add step
	always_comb begin
		xs  = in_w.x >>> idx;
		ys  = in_w.y >>> idx;
		at  = signed'({2'b00, atan_q30(idx)});
		nxt = in_w;
		if (!in_w.z[31]) begin
			nxt.x = in_w.x - ys;
			nxt.y = in_w.y + xs;
			nxt.z = in_w.z - at;
		end else begin
			nxt.x = in_w.x + ys;
			nxt.y = in_w.y - xs;
			nxt.z = in_w.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w <= nxt;
		end
	end

endmodule

[rtl/core/prrd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// prrd_sqrt_cell
// One digit of the integer square root: takes two radicand bits, decides one
// root bit, registered.
// ----------------------------------------------------------------------------
module prrd_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  prrd_pkg::sqrt_t in_w,
	output logic            out_v,
	output prrd_pkg::sqrt_t out_w
);
	import prrd_pkg::*;

	sqrt_t nxt;
	logic [REM_W+1:0] t, trial;

	// trial subtract
	always_comb begin
		t       = {in_w.rem, in_w.rad[RAD_W-1 -: 2]};
		trial   = {2'b00, in_w.root, 2'b01};
		nxt.rad = {in_w.rad[RAD_W-3:0], 2'b00};
		if (t >= trial) begin
			nxt.rem  = REM_W'(t - trial);
			nxt.root = {in_w.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = t[REM_W-1:0];
			nxt.root = {in_w.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w <= nxt;
		end
	end

endmodule

[rtl/core/point_to_rotated_rect_distance.sv]
// ----------------------------------------------------------------------------
// point_to_rotated_rect_distance
// Distance from a query point to a scaled, rotated rectangle: a row of
// rotation cells, product and excess stages, then a row of root cells.
// ----------------------------------------------------------------------------
// throughput: one word per cycle; the pipeline holds while the output stalls
// each rotation cell and each root cell is one stage, so the two cell rows
// make up most of the pipeline
// reset: registers return to zero bounds, unit scales and zero angle;
// the pipeline empties at once
module point_to_rotated_rect_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] query_x,
	input  logic signed [15:0] query_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] distance,
	output logic        saturated
);
	import prrd_pkg::*;

	logic signed [15:0] left_q, right_q, top_q, bottom_q;
	logic [15:0] xscale_q, yscale_q, angle_q;
	logic en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			xscale_q <= 16'd4096;
			yscale_q <= 16'd4096;
			angle_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_XSCALE: xscale_q <= cfg_data;
				REG_YSCALE: yscale_q <= cfg_data;
				REG_ANGLE:  angle_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output word is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: centre offset, half-extent products, starting angle
	logic signed [16:0] sum_x, sum_y, dif_x, dif_y;
	logic [16:0] span_x, span_y;
	logic [13:0] rem_a;
	logic [1:0]  quad_a;
	logic [14:0] mag_a;
	logic [44:0] zprod;
	logic signed [31:0] z0;
	cordic_t w0;

	always_comb begin
		sum_x  = 17'(left_q) + 17'(right_q);
		sum_y  = 17'(top_q) + 17'(bottom_q);
		dif_x  = 17'(right_q) - 17'(left_q);
		dif_y  = 17'(bottom_q) - 17'(top_q);
		span_x = dif_x[16] ? 17'(-dif_x) : 17'(dif_x);
		span_y = dif_y[16] ? 17'(-dif_y) : 17'(dif_y);
		rem_a  = angle_q[13:0];
		quad_a = angle_q[15:14];
		if (rem_a[13]) begin
			mag_a  = 15'h4000 - {1'b0, rem_a};
			quad_a = quad_a + 2'd1;
		end else begin
			mag_a = {1'b0, rem_a};
		end
		zprod = 45'(mag_a) * 45'(QUARTER_PI);
		z0    = rem_a[13] ? -signed'(zprod[44:13]) : signed'(zprod[44:13]);
	end

	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w0.x    <= CORDIC_K;
			w0.y    <= '0;
			w0.z    <= z0;
			w0.quad <= quad_a;
			w0.dx   <= {query_x[15], query_x, 1'b0} - {sum_x[16], sum_x};
			w0.dy   <= {query_y[15], query_y, 1'b0} - {sum_y[16], sum_y};
			w0.hx   <= 33'(span_x) * 33'(xscale_q);
			w0.hy   <= 33'(span_y) * 33'(yscale_q);
		end
	end

	// row of rotation cells
	logic    cv [CORDIC_N+1];
	cordic_t cw [CORDIC_N+1];
	assign cv[0] = v_s1;
	assign cw[0] = w0;

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		prrd_cordic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.idx   (IDX_W'(i)),
			.in_v  (cv[i]),
			.in_w  (cw[i]),
			.out_v (cv[i+1]),
			.out_w (cw[i+1])
		);
	end

	cordic_t ce;
	assign ce = cw[CORDIC_N];

	// stage 2: quadrant applied to cos and sin
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [33:0] cs_s2, sn_s2;
	logic signed [17:0] dx_s2, dy_s2;
	logic [32:0] hx_s2, hy_s2, hx_s3, hy_s3, hx_s4, hy_s4;
	logic signed [51:0] pxc_s3, pys_s3, pyc_s3, pxs_s3;
	logic signed [52:0] rx_s4, ry_s4;
	logic [25:0] ex_s5, ey_s5;
	logic [51:0] sqx_s6, sqy_s6;
	logic [RAD_W-1:0] sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= cv[CORDIC_N];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// excess beyond half-extent, rounded to 2^-4
	function automatic logic [25:0] excess(input logic signed [52:0] v,
		input logic [32:0] h);
		logic [52:0] a;
		logic signed [55:0] e;
		logic [55:0] r;
		a = v[52] ? 53'(-v) : 53'(v);
		e = signed'(56'(a)) - signed'(56'({h, 18'b0}));
		r = 56'(e) + 56'(1 << 26);
		if (e <= 0) begin
			return '0;
		end
		return r[52:27];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			case (ce.quad)
				2'd0: begin
					cs_s2 <= ce.x;
					sn_s2 <= ce.y;
				end
				2'd1: begin
					cs_s2 <= -ce.y;
					sn_s2 <= ce.x;
				end
				2'd2: begin
					cs_s2 <= -ce.x;
					sn_s2 <= -ce.y;
				end
				default: begin
					cs_s2 <= ce.y;
					sn_s2 <= -ce.x;
				end
			endcase
			dx_s2 <= ce.dx;
			dy_s2 <= ce.dy;
			hx_s2 <= ce.hx;
			hy_s2 <= ce.hy;
			// stage 3: products
			pxc_s3 <= 52'(dx_s2) * 52'(cs_s2);
			pys_s3 <= 52'(dy_s2) * 52'(sn_s2);
			pyc_s3 <= 52'(dy_s2) * 52'(cs_s2);
			pxs_s3 <= 52'(dx_s2) * 52'(sn_s2);
			hx_s3  <= hx_s2;
			hy_s3  <= hy_s2;
			// stage 4: rotated coordinates
			rx_s4 <= 53'(pxc_s3) + 53'(pys_s3);
			ry_s4 <= 53'(pyc_s3) - 53'(pxs_s3);
			hx_s4 <= hx_s3;
			hy_s4 <= hy_s3;
			// stage 5: excess per axis
			ex_s5 <= excess(rx_s4, hx_s4);
			ey_s5 <= excess(ry_s4, hy_s4);
			// stage 6: squares
			sqx_s6 <= 52'(ex_s5) * 52'(ex_s5);
			sqy_s6 <= 52'(ey_s5) * 52'(ey_s5);
			// stage 7: sum of squares
			sum_s7 <= RAD_W'(sqx_s6) + RAD_W'(sqy_s6);
		end
	end

	// row of root cells
	logic  sv [ROOT_W+1];
	sqrt_t sw [ROOT_W+1];
	assign sv[0]      = v_s7;
	assign sw[0].rad  = sum_s7;
	assign sw[0].root = '0;
	assign sw[0].rem  = '0;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		prrd_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.in_v  (sv[k]),
			.in_w  (sw[k]),
			.out_v (sv[k+1]),
			.out_w (sw[k+1])
		);
	end

	// output word: round to whole units and clip
	logic [ROOT_W-4:0] rnd;
	assign rnd = (ROOT_W-3)'(({1'b0, sw[ROOT_W].root} + (ROOT_W+1)'(8)) >> 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= sv[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rnd > (ROOT_W-3)'(DIST_MAX)) begin
				distance  <= DIST_MAX;
				saturated <= 1'b1;
			end else begin
				distance  <= rnd[19:0];
				saturated <= 1'b0;
			end
		end
	end

	// checks
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> distance == DIST_MAX)
		else $error("saturated word without maximum distance");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no held output word");

	a_root_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv[ROOT_W] && en |=> out_valid)
		else $error("finished root lost before output");

	a_entry_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word not in first stage");

endmodule
